FILE: rtl/fprp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fprp_pkg: shared types and constants of the request parser
// Status codes, item codes, result kinds and the per-type item sequences.
// ---------------------------------------------------------------------------
package fprp_pkg;

  localparam int MaxWalkNames = 16;

  localparam logic [1:0] KIND_FIELD = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PKT  = 2'd1;
  localparam logic [1:0] ST_PATH = 2'd2;
  localparam logic [1:0] ST_VER  = 2'd3;

  localparam logic [4:0] IT_END    = 5'd0;
  localparam logic [4:0] IT_F1     = 5'd1;
  localparam logic [4:0] IT_F2     = 5'd2;
  localparam logic [4:0] IT_F4     = 5'd3;
  localparam logic [4:0] IT_F8     = 5'd4;
  localparam logic [4:0] IT_STR    = 5'd5;
  localparam logic [4:0] IT_NAME   = 5'd6;
  localparam logic [4:0] IT_NWNAME = 5'd7;
  localparam logic [4:0] IT_WNAMES = 5'd8;
  localparam logic [4:0] IT_RCOUNT = 5'd9;
  localparam logic [4:0] IT_WCOUNT = 5'd10;
  localparam logic [4:0] IT_DATA   = 5'd11;
  localparam logic [4:0] IT_VMSIZE = 5'd12;
  localparam logic [4:0] IT_VSTR   = 5'd13;
  localparam logic [4:0] IT_STATN  = 5'd14;
  localparam logic [4:0] IT_STATSZ = 5'd15;
  localparam logic [4:0] IT_SSTR   = 5'd16;

  localparam logic [3:0] ROW_NONE = 4'd15;
  localparam logic [7:0] TYPE_VERSION = 8'd100;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mtype;
    logic [15:0] tag;
    logic [4:0]  pos;
    logic [63:0] value;
    logic [1:0]  status;
    logic        eom;
  } result_t;

  // map a type byte to its sequence row
  function automatic logic [3:0] type_row(input logic [7:0] t);
    logic [3:0] r;
    case (t)
      8'd100: r = 4'd0;
      8'd102: r = 4'd1;
      8'd104: r = 4'd2;
      8'd108: r = 4'd3;
      8'd110: r = 4'd4;
      8'd112: r = 4'd5;
      8'd114: r = 4'd6;
      8'd116: r = 4'd7;
      8'd118: r = 4'd8;
      8'd120, 8'd122, 8'd124: r = 4'd9;
      8'd126: r = 4'd10;
      default: r = ROW_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] min_body(input logic [3:0] r);
    logic [4:0] m;
    case (r)
      4'd0: m = 5'd6;
      4'd1: m = 5'd8;
      4'd2: m = 5'd12;
      4'd3: m = 5'd2;
      4'd4: m = 5'd10;
      4'd5: m = 5'd5;
      4'd6: m = 5'd11;
      4'd7: m = 5'd16;
      4'd8: m = 5'd16;
      4'd9: m = 5'd4;
      4'd10: m = 5'd6;
      default: m = 5'd0;
    endcase
    return m;
  endfunction

  // item sequence table
  function automatic logic [4:0] item_at(input logic [3:0] r, input logic [4:0] i);
    logic [4:0] it;
    it = IT_END;
    case (r)
      4'd0: case (i)
        5'd0: it = IT_VMSIZE;
        5'd1: it = IT_VSTR;
        default: it = IT_END;
      endcase
      4'd1: case (i)
        5'd0: it = IT_F4;
        5'd1, 5'd2: it = IT_STR;
        default: it = IT_END;
      endcase
      4'd2: case (i)
        5'd0, 5'd1: it = IT_F4;
        5'd2, 5'd3: it = IT_STR;
        default: it = IT_END;
      endcase
      4'd3: it = (i == 5'd0) ? IT_F2 : IT_END;
      4'd4: case (i)
        5'd0, 5'd1: it = IT_F4;
        5'd2: it = IT_NWNAME;
        5'd3: it = IT_WNAMES;
        default: it = IT_END;
      endcase
      4'd5: case (i)
        5'd0: it = IT_F4;
        5'd1: it = IT_F1;
        default: it = IT_END;
      endcase
      4'd6: case (i)
        5'd0, 5'd2: it = IT_F4;
        5'd1: it = IT_NAME;
        5'd3: it = IT_F1;
        default: it = IT_END;
      endcase
      4'd7: case (i)
        5'd0: it = IT_F4;
        5'd1: it = IT_F8;
        5'd2: it = IT_RCOUNT;
        default: it = IT_END;
      endcase
      4'd8: case (i)
        5'd0: it = IT_F4;
        5'd1: it = IT_F8;
        5'd2: it = IT_WCOUNT;
        5'd3: it = IT_DATA;
        default: it = IT_END;
      endcase
      4'd9: it = (i == 5'd0) ? IT_F4 : IT_END;
      4'd10: case (i)
        5'd0: it = IT_F4;
        5'd1: it = IT_STATN;
        5'd2: it = IT_STATSZ;
        5'd3: it = IT_F2;
        5'd4: it = IT_F4;
        5'd5: it = IT_F1;
        5'd6: it = IT_F4;
        5'd7: it = IT_F8;
        5'd8, 5'd9, 5'd10: it = IT_F4;
        5'd11: it = IT_F8;
        5'd12, 5'd13, 5'd14, 5'd15: it = IT_SSTR;
        default: it = IT_END;
      endcase
      default: it = IT_END;
    endcase
    return it;
  endfunction

  function automatic logic [3:0] item_width(input logic [4:0] it);
    logic [3:0] w;
    case (it)
      IT_F1: w = 4'd1;
      IT_F4, IT_RCOUNT, IT_WCOUNT, IT_VMSIZE: w = 4'd4;
      IT_F8: w = 4'd8;
      default: w = 4'd2;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h39;
      3'd1: c = 8'h50;
      3'd2: c = 8'h32;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/file_protocol_request_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// file_protocol_request_parser: server-side request stream parser
// Splits a byte stream of file protocol requests into field, byte and end
// results with a status.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one request byte per transaction in tdata.
//   m_axis carries one result per transaction; tlast marks the end result.
//   cfg writes initial_msize (index 0) or min_msize (index 1); write only
//   while idle. Writing initial_msize also reloads the negotiated size.
// Throughput: one byte per cycle; a byte yields at most two results, and the
//   engine pauses input while the four-entry result queue has fewer than two
//   free slots, so the output port delivering one result per cycle sets the
//   sustained rate when bytes produce two results.
// Results are registered in the result queue before they appear on m_axis.
// Reset: synchronous; queue empties, registers return to 8192 and 4096,
//   parser waits for a length field.
// Receiver stall: results queue up; once the queue is near full, s_axis
//   tready drops until the receiver drains it.
// ---------------------------------------------------------------------------
module file_protocol_request_parser
  import fprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // field_position[4:0], field_value[68:5], pad to 72
  output logic [71:0] m_axis_tdata,
  // result_kind[1:0], message_type[9:2], message_tag[25:10], end_status[27:26]
  output logic [27:0] m_axis_tuser,
  output logic        m_axis_tlast,   // end_of_message
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [0:0] REG_INITIAL_MSIZE = 1'd0;
  localparam logic [0:0] REG_MIN_MSIZE     = 1'd1;

  logic [31:0] min_msize;
  logic        cfg_wr, cfg_wr0, room, push0, push1, accept;
  result_t     res0, res1, qout;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_wr0   = cfg_wr && cfg_index == REG_INITIAL_MSIZE;

  // configuration register; initial_msize goes straight into the engine
  always_ff @(posedge clk) begin
    if (rst) begin
      min_msize <= 32'd4096;
    end else if (cfg_wr) begin
      if (cfg_index == REG_MIN_MSIZE) min_msize <= cfg_data;
    end
  end

  assign s_axis_tready = room;
  assign accept = s_axis_tvalid && s_axis_tready;

  fprp_front u_front (
    .clk(clk), .rst(rst), .byte_valid(accept), .byte_data(s_axis_tdata),
    .cfg_wr0(cfg_wr0), .initial_msize(cfg_data), .min_msize(min_msize),
    .push0(push0), .push1(push1), .res0(res0), .res1(res1)
  );

  fprp_queue u_queue (
    .clk(clk), .rst(rst), .push0(push0), .push1(push1), .res0(res0),
    .res1(res1), .room(room), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(qout)
  );

  assign m_axis_tdata = {3'd0, qout.value, qout.pos};
  assign m_axis_tuser = {qout.status, qout.tag, qout.mtype, qout.kind};
  assign m_axis_tlast = qout.eom;

endmodule

FILE: rtl/fprp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fprp_front: per-byte parse engine
// Accepts one stream byte per cycle, classifies it against the message
// layout and pushes up to two result items into the queue.
// ---------------------------------------------------------------------------
module fprp_front
  import fprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  input  logic        cfg_wr0,
  input  logic [31:0] initial_msize,
  input  logic [31:0] min_msize,
  output logic        push0,
  output logic        push1,
  output result_t     res0,
  output result_t     res1
);

  localparam logic [2:0] PH_LEN   = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_TAG   = 3'd2;
  localparam logic [2:0] PH_FIELD = 3'd3;
  localparam logic [2:0] PH_STR   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_SKIP  = 3'd7;

  logic [31:0] negotiated_msize, negotiated_msize_next;
  logic        version_accepted, version_accepted_next;
  logic [31:0] message_length, message_length_next;
  logic [31:0] byte_position, byte_position_next;
  logic [7:0]  header_type, header_type_next;
  logic [15:0] header_tag, header_tag_next;
  logic [63:0] field_shift, field_shift_next;
  logic [4:0]  field_counter, field_counter_next;
  logic [15:0] string_remaining, string_remaining_next;
  logic [4:0]  walk_names_left, walk_names_left_next;
  logic [1:0]  pending_status, pending_status_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [4:0]  item_index, item_index_next;
  logic [3:0]  field_bytes_left, field_bytes_left_next;
  logic [31:0] stat_end, stat_end_next;
  logic [31:0] proposed_msize, proposed_msize_next;

  // combinational scratch
  logic [31:0] bp1, rem, slft, len, lim;
  logic [3:0]  row;
  logic [4:0]  it, nit, ei;
  logic [63:0] fs, v;
  logic [15:0] sr;
  logic [1:0]  st;
  logic        bad, emit_f, enter, sfin;
  logic [5:0]  vidx;
  logic [64:0] sum65;

  always_comb begin
    negotiated_msize_next = negotiated_msize;
    version_accepted_next = version_accepted;
    message_length_next   = message_length;
    byte_position_next    = byte_position;
    header_type_next      = header_type;
    header_tag_next       = header_tag;
    field_shift_next      = field_shift;
    field_counter_next    = field_counter;
    string_remaining_next = string_remaining;
    walk_names_left_next  = walk_names_left;
    pending_status_next   = pending_status;
    parse_phase_next      = parse_phase;
    item_index_next       = item_index;
    field_bytes_left_next = field_bytes_left;
    stat_end_next         = stat_end;
    proposed_msize_next   = proposed_msize;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = '0;
    res1  = '0;
    bp1   = byte_position + 32'd1;
    rem   = (message_length > bp1) ? message_length - bp1 : 32'd0;
    slft  = (stat_end > bp1) ? stat_end - bp1 : 32'd0;
    row   = type_row(header_type);
    it    = item_at(row, item_index);
    len   = {byte_data, field_shift[23:0]};
    lim   = (negotiated_msize >= 32'd11) ? negotiated_msize - 32'd11 : 32'd0;
    fs    = {byte_data, field_shift[63:8]};
    v     = fs >> (7'd64 - {item_width(it), 3'd0});
    sr    = string_remaining - 16'd1;
    vidx  = field_shift[5:0] - string_remaining[5:0];
    sum65 = {33'd0, bp1} + {1'b0, v};
    bad   = 1'b0;
    emit_f = 1'b0;
    enter  = 1'b0;
    sfin   = 1'b0;
    ei     = item_index;
    nit    = IT_END;
    st     = ST_OK;

    if (cfg_wr0) begin
      negotiated_msize_next = initial_msize;
    end

    if (byte_valid) begin
      if (parse_phase == PH_LEN) begin
        byte_position_next = bp1;
        case (byte_position[1:0])
          2'd0: field_shift_next[7:0]   = byte_data;
          2'd1: field_shift_next[15:8]  = byte_data;
          2'd2: field_shift_next[23:16] = byte_data;
          default: field_shift_next[31:24] = byte_data;
        endcase
        if (byte_position[1:0] == 2'd3) begin
          field_shift_next = '0;
          if (len < 32'd7 || len > negotiated_msize) begin
            push0 = 1'b1;
            res0  = '{kind: KIND_END, mtype: 8'd0, tag: 16'd0, pos: 5'd0,
                      value: 64'd0, status: ST_PKT, eom: 1'b1};
            header_type_next = 8'd0;
            header_tag_next  = 16'd0;
            byte_position_next = '0;
          end else begin
            message_length_next = len;
            parse_phase_next = PH_TYPE;
          end
        end
      end else begin
        byte_position_next = bp1;
        case (parse_phase)
          PH_TYPE: begin
            header_type_next = byte_data;
            parse_phase_next = PH_TAG;
          end
          PH_TAG: begin
            if (bp1 == 32'd6) begin
              header_tag_next = {8'd0, byte_data};
            end else begin
              header_tag_next = {byte_data, header_tag[7:0]};
              if (!version_accepted && header_type != TYPE_VERSION) begin
                bad = 1'b1; st = ST_PKT;
              end else if (row == ROW_NONE) begin
                bad = 1'b1; st = ST_PKT;
              end else if (message_length - 32'd7 < {27'd0, min_body(row)}) begin
                bad = 1'b1; st = ST_PKT;
              end else begin
                ei = 5'd0;
                field_counter_next = 5'd0;
                enter = 1'b1;
              end
            end
          end
          PH_FIELD: begin
            field_shift_next = fs;
            field_bytes_left_next = (field_bytes_left > 4'd0) ?
                                    field_bytes_left - 4'd1 : 4'd0;
            if (field_bytes_left <= 4'd1) begin
              // field complete
              case (it)
                IT_RCOUNT: begin
                  v = (v > {32'd0, lim}) ? {32'd0, lim} : v;
                  emit_f = 1'b1;
                end
                IT_WCOUNT: begin
                  if (v < {32'd0, rem}) begin
                    bad = 1'b1; st = ST_PKT;
                  end else begin
                    v = (v > {32'd0, lim}) ? {32'd0, lim} : v;
                    emit_f = 1'b1;
                  end
                end
                IT_VMSIZE: begin
                  if (v < {32'd0, min_msize}) begin
                    bad = 1'b1; st = ST_PKT;
                  end else begin
                    proposed_msize_next = v[31:0];
                    emit_f = 1'b1;
                  end
                end
                IT_NWNAME: begin
                  if (v > 64'(MaxWalkNames)) begin
                    bad = 1'b1; st = ST_PATH;
                  end else begin
                    walk_names_left_next = v[4:0];
                    emit_f = 1'b1;
                  end
                end
                IT_STATN: begin
                  if (v > {32'd0, rem} || v < 64'd49) begin
                    bad = 1'b1; st = ST_PKT;
                  end else begin
                    stat_end_next = bp1 + v[31:0];
                    emit_f = 1'b1;
                  end
                end
                IT_STATSZ: begin
                  if (v < 64'd47 || sum65 > {33'd0, stat_end}) begin
                    bad = 1'b1; st = ST_PKT;
                  end else begin
                    stat_end_next = bp1 + v[31:0];
                    emit_f = 1'b1;
                  end
                end
                IT_STR, IT_NAME, IT_WNAMES, IT_VSTR, IT_SSTR: begin
                  if (it == IT_NAME) begin
                    bad = (v < 64'd1) || ((v + 64'd5) > {32'd0, rem});
                  end else if (it == IT_SSTR) begin
                    bad = v > {32'd0, slft};
                  end else begin
                    bad = v > {32'd0, rem};
                  end
                  if (bad) begin
                    st = ST_PKT;
                  end else if (it == IT_WNAMES && v == 64'd0) begin
                    bad = 1'b1; st = ST_PATH;
                  end else if (it == IT_VSTR && v < 64'd6) begin
                    bad = 1'b1; st = ST_VER;
                  end else begin
                    push0 = 1'b1;
                    res0  = '{kind: KIND_FIELD, mtype: header_type, tag: header_tag,
                              pos: field_counter, value: v, status: ST_OK, eom: 1'b0};
                    field_shift_next = v;
                    string_remaining_next = v[15:0];
                    if (v == 64'd0) begin
                      sfin = 1'b1;
                    end else begin
                      parse_phase_next = PH_STR;
                    end
                  end
                end
                default: emit_f = 1'b1;
              endcase
              if (emit_f) begin
                push0 = 1'b1;
                res0  = '{kind: KIND_FIELD, mtype: header_type, tag: header_tag,
                          pos: field_counter, value: v, status: ST_OK, eom: 1'b0};
                field_counter_next = field_counter + 5'd1;
                ei = item_index + 5'd1;
                enter = 1'b1;
              end
            end
          end
          PH_STR: begin
            if (it == IT_VSTR && vidx < 6'd6 && field_shift[63:6] == 58'd0 &&
                byte_data != version_char(vidx[2:0])) begin
              bad = 1'b1; st = ST_VER;
            end else if (it == IT_VSTR && field_shift[63:16] == 48'd0 &&
                         {48'd0, field_shift[15:0]} - {48'd0, string_remaining} < 64'd6 &&
                         byte_data != version_char(vidx[2:0])) begin
              bad = 1'b1; st = ST_VER;
            end else begin
              push0 = 1'b1;
              res0  = '{kind: KIND_BYTE, mtype: header_type, tag: header_tag,
                        pos: field_counter, value: {56'd0, byte_data},
                        status: ST_OK, eom: 1'b0};
              string_remaining_next = sr;
              if (sr == 16'd0) sfin = 1'b1;
            end
          end
          PH_DATA: begin
            push0 = 1'b1;
            res0  = '{kind: KIND_BYTE, mtype: header_type, tag: header_tag,
                      pos: field_counter, value: {56'd0, byte_data},
                      status: ST_OK, eom: 1'b0};
          end
          default: ;
        endcase

        // string finished: next name or next item
        if (sfin) begin
          field_counter_next = field_counter + 5'd1;
          if (it == IT_WNAMES) begin
            walk_names_left_next = walk_names_left - 5'd1;
            ei = item_index;
          end else begin
            ei = item_index + 5'd1;
          end
          enter = 1'b1;
        end

        // enter next item; an empty name list skips one entry
        if (enter) begin
          nit = item_at(row, ei);
          if (nit == IT_WNAMES && walk_names_left_next == 5'd0) begin
            ei  = ei + 5'd1;
            nit = item_at(row, ei);
          end
          item_index_next = ei;
          if (nit == IT_END) begin
            parse_phase_next = PH_DONE;
          end else if (nit == IT_DATA) begin
            parse_phase_next = PH_DATA;
          end else if (nit == IT_SSTR && slft < 32'd2) begin
            bad = 1'b1; st = ST_PKT;
          end else begin
            parse_phase_next = PH_FIELD;
            field_bytes_left_next = item_width(nit);
            field_shift_next = '0;
          end
        end

        if (bad) begin
          if (pending_status == ST_OK) pending_status_next = st;
          parse_phase_next = PH_SKIP;
        end

        // end of message
        if (bp1 >= message_length) begin
          st = pending_status_next;
          if (st == ST_OK && parse_phase_next != PH_DONE && parse_phase_next != PH_DATA) begin
            st = ST_PKT;
          end
          if (st == ST_OK && header_type_next == TYPE_VERSION) begin
            if (proposed_msize_next < negotiated_msize) begin
              negotiated_msize_next = proposed_msize_next;
            end
            version_accepted_next = 1'b1;
          end
          if (push0) begin
            push1 = 1'b1;
            res1  = '{kind: KIND_END, mtype: header_type_next, tag: header_tag_next,
                      pos: 5'd0, value: 64'd0, status: st, eom: 1'b1};
          end else begin
            push0 = 1'b1;
            res0  = '{kind: KIND_END, mtype: header_type_next, tag: header_tag_next,
                      pos: 5'd0, value: 64'd0, status: st, eom: 1'b1};
          end
          byte_position_next = '0;
          field_shift_next   = '0;
          message_length_next = '0;
          field_counter_next = '0;
          string_remaining_next = '0;
          walk_names_left_next = '0;
          pending_status_next = ST_OK;
          parse_phase_next = PH_LEN;
          item_index_next = '0;
          field_bytes_left_next = '0;
          stat_end_next = '0;
          proposed_msize_next = '0;
        end
      end
    end
  end

  // hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      negotiated_msize <= 32'd8192;
      version_accepted <= 1'b0;
      message_length   <= '0;
      byte_position    <= '0;
      header_type      <= '0;
      header_tag       <= '0;
      field_shift      <= '0;
      field_counter    <= '0;
      string_remaining <= '0;
      walk_names_left  <= '0;
      pending_status   <= ST_OK;
      parse_phase      <= PH_LEN;
      item_index       <= '0;
      field_bytes_left <= '0;
      stat_end         <= '0;
      proposed_msize   <= '0;
    end else begin
      negotiated_msize <= negotiated_msize_next;
      version_accepted <= version_accepted_next;
      message_length   <= message_length_next;
      byte_position    <= byte_position_next;
      header_type      <= header_type_next;
      header_tag       <= header_tag_next;
      field_shift      <= field_shift_next;
      field_counter    <= field_counter_next;
      string_remaining <= string_remaining_next;
      walk_names_left  <= walk_names_left_next;
      pending_status   <= pending_status_next;
      parse_phase      <= parse_phase_next;
      item_index       <= item_index_next;
      field_bytes_left <= field_bytes_left_next;
      stat_end         <= stat_end_next;
      proposed_msize   <= proposed_msize_next;
    end
  end

  // a second result only ever follows a first one
  assert property (@(posedge clk) disable iff (rst) push1 |-> push0)
    else $error("second push without first");
  assert property (@(posedge clk) disable iff (rst) push1 |-> res1.eom && !res0.eom)
    else $error("second result is not the message end");
  assert property (@(posedge clk) disable iff (rst) (push0 && !byte_valid) |-> 1'b0)
    else $error("result without a byte");

endmodule

FILE: rtl/fprp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fprp_queue: result queue between engine and output port
// Takes up to two results per cycle, delivers one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module fprp_queue
  import fprp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t res0,
  input  result_t res1,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int Depth = 4;
  localparam int AW = $clog2(Depth);

  result_t mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          pop;
  logic [1:0]    npush;

  assign pop       = out_valid && out_ready;
  assign npush     = {1'b0, push0} + {1'b0, push1};
  assign out_valid = count != '0;
  assign out_data  = mem[rptr];
  // two free slots are needed since one byte can cause two results
  assign room      = count <= (AW+1)'(Depth - 2);

  // write and advance
  always_ff @(posedge clk) begin
    if (push0) mem[wptr] <= res0;
    if (push1) mem[wptr + AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(npush);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(npush) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (push0 || push1) |-> room)
    else $error("push without room");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result lost");

endmodule
